### src/ofem_pkg.sv
// package for the optical flow error metrics core
// holds the sequencer state type, cordic table and fixed constants; no dependencies
package ofem_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_W     = 62;
    localparam int ZW           = 26;

    localparam logic signed [ZW-1:0] DEG90_Q16  = ZW'(5898240);
    localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);

    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        logic [22:0] r;
        unique case (i)
            5'd0:    r = 23'd2949120;
            5'd1:    r = 23'd1740967;
            5'd2:    r = 23'd919879;
            5'd3:    r = 23'd466945;
            5'd4:    r = 23'd234379;
            5'd5:    r = 23'd117304;
            5'd6:    r = 23'd58666;
            5'd7:    r = 23'd29335;
            5'd8:    r = 23'd14668;
            5'd9:    r = 23'd7334;
            5'd10:   r = 23'd3667;
            5'd11:   r = 23'd1833;
            5'd12:   r = 23'd917;
            5'd13:   r = 23'd458;
            5'd14:   r = 23'd229;
            5'd15:   r = 23'd115;
            5'd16:   r = 23'd57;
            5'd17:   r = 23'd29;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MUL    = 11'b000_0000_0010,
        S_SUMS   = 11'b000_0000_0100,
        S_SQRTC  = 11'b000_0000_1000,
        S_CORDIC = 11'b000_0001_0000,
        S_SQRTE  = 11'b000_0010_0000,
        S_ACC    = 11'b000_0100_0000,
        S_DIVA   = 11'b000_1000_0000,
        S_DIVE   = 11'b001_0000_0000,
        S_DIVB   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

endpackage

### src/ofem_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on nothing
module ofem_isqrt #(
    parameter int W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_value,
    output logic             o_done,
    output logic [W/2-1:0]   o_root
);
    localparam int STEPS = W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_val;
    logic [W/2-1:0] r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W+1:0] w_trial;
    logic [W+1:0] w_cur;

    always_comb begin
        w_cur   = {r_rem, r_val[W-1:W-2]};
        w_trial = {{(W/2){1'b0}}, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
                r_rem  <= '0;
                r_val  <= i_value;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[W-3:0], 2'b00};
                if (w_cur >= w_trial) begin
                    r_rem  <= W'(w_cur - w_trial);
                    r_root <= {r_root[W/2-2:0], 1'b1};
                end else begin
                    r_rem  <= W'(w_cur);
                    r_root <= {r_root[W/2-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### src/ofem_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing
module ofem_divider #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quot;
    logic [DW:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_shift;

    assign w_shift = {r_rem[DW-1:0], r_quot[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quot <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_shift >= {1'b0, i_den}) begin
                    r_rem  <= w_shift - {1'b0, i_den};
                    r_quot <= {r_quot[NW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### src/optical_flow_error_metrics_core.sv
// Per-pixel angular and endpoint error statistics over one frame, one pixel per beat.
// A counted pixel runs through products and sums, a 32-step square root of the
// cross product norm, 18 cordic steps, and a 32-step square root of the endpoint error, all run
// by one sequencer over shared iterative units; a skipped pixel that is not last leaves the
// sequencer idle. A last pixel adds three 64-step divisions before the result beat. The input
// stalls for the whole time an item is at work and until the result beat is taken.
// depends on ofem_pkg, ofem_isqrt, ofem_divider
module optical_flow_error_metrics_core
    import ofem_pkg::*;
#(
    parameter int COUNT_BITS = 22,
    parameter int FLOW_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_truth_u,
    input  logic signed [15:0] i_truth_v,
    input  logic signed [15:0] i_est_u,
    input  logic signed [15:0] i_est_v,
    input  logic               i_pixel_enabled,
    input  logic               i_truth_unknown,
    input  logic               i_est_unknown,
    input  logic               i_last_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_mean_angle_deg,
    output logic [16:0]        o_mean_endpoint_error,
    output logic [16:0]        o_bad_fraction,
    output logic [22:0]        o_counted_pixels,
    output logic               o_stats_valid
);
    localparam int FW  = (FLOW_BITS < 16) ? FLOW_BITS : 16;
    localparam int NW  = COUNT_BITS + 1;

    t_state r_state;
    logic [16:0] r_thresh;

    logic signed [16:0] r_tu, r_tv, r_eu, r_ev;
    logic               r_last;
    logic signed [33:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [22:0] r_c1, r_c2;
    logic signed [34:0] r_dot;
    logic [63:0]        r_cs;
    logic [35:0]        r_es;
    logic [63:0]        r_angle_sum;
    logic [63:0]        r_ep_sum;
    logic [NW-1:0]      r_bad;
    logic [NW-1:0]      r_cnt;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [4:0]         r_i;
    logic               r_sqrt_go, r_div_go;
    logic [15:0]        r_o_angle;
    logic [16:0]        r_o_ep, r_o_bad;
    logic [22:0]        r_o_cnt;
    logic               r_o_sv;
    logic               r_ovalid;

    // shared sqrt
    logic [63:0] w_sq_in;
    logic        w_sq_done;
    logic [31:0] w_sq_root;
    assign w_sq_in = (r_state == S_SQRTC) ? r_cs : {26'd0, r_es, 2'b00};

    ofem_isqrt #(.W(64)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sqrt_go),
        .i_value(w_sq_in), .o_done(w_sq_done), .o_root(w_sq_root)
    );

    // shared divider
    logic [63:0] w_num;
    logic [63:0] w_den_w;
    logic [31:0] w_den;
    logic        w_dv_done;
    logic [63:0] w_quot;
    logic [NW-1:0] w_half;
    assign w_half = r_cnt >> 1;
    always_comb begin
        w_den_w = 64'(r_cnt);
        w_num   = r_ep_sum + 64'(w_half);
        unique case (r_state)
            S_DIVA: begin
                w_num   = r_angle_sum + (64'(r_cnt) << 7);
                w_den_w = 64'(r_cnt) << 8;
            end
            S_DIVB:  w_num = (64'(r_bad) << 16) + 64'(w_half);
            default: w_num = r_ep_sum + 64'(w_half);
        endcase
        w_den = w_den_w[31:0];
    end

    ofem_divider #(.NW(64), .DW(32)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(w_num), .i_den(w_den), .o_done(w_dv_done), .o_quot(w_quot)
    );

    function automatic logic signed [16:0] sx(input logic [15:0] v);
        logic [FW-1:0] t;
        t = v[FW-1:0];
        return 17'($signed(t));
    endfunction

    logic w_accept;
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;

    logic signed [CORDIC_W-1:0] w_xs, w_ys;
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    logic signed [ZW-1:0] w_at;
    assign w_at = ZW'($signed({1'b0, atan_deg(r_i)}));

    logic signed [35:0] w_dotw;
    logic [31:0] w_cr;
    logic [33:0] w_th2;
    assign w_dotw = 36'(r_dot);
    assign w_cr   = w_sq_root;
    assign w_th2  = r_thresh * r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= 17'd192;
            r_angle_sum <= '0;
            r_ep_sum    <= '0;
            r_bad       <= '0;
            r_cnt       <= '0;
            r_sqrt_go   <= 1'b0;
            r_div_go    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_sqrt_go <= 1'b0;
            r_div_go  <= 1'b0;
            if (i_cfg_valid) r_thresh <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_tu <= sx(i_truth_u); r_tv <= sx(i_truth_v);
                    r_eu <= sx(i_est_u);   r_ev <= sx(i_est_v);
                    r_last <= i_last_pixel;
                    if (i_pixel_enabled && !i_truth_unknown && !i_est_unknown
                        && !r_cnt[COUNT_BITS]) begin
                        r_state <= S_MUL;
                    end else if (i_last_pixel) begin
                        r_state  <= S_DIVA;
                        r_div_go <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_p1 <= r_tu * r_eu; r_p2 <= r_tv * r_ev;
                    r_p3 <= r_tu * r_ev; r_p4 <= r_tv * r_eu;
                    r_c1 <= 23'(r_tv - r_ev) <<< 6;
                    r_c2 <= 23'(r_eu - r_tu) <<< 6;
                    r_p5 <= (r_tu - r_eu) * (r_tu - r_eu);
                    r_p6 <= (r_tv - r_ev) * (r_tv - r_ev);
                    r_state <= S_SUMS;
                end
                S_SUMS: begin
                    r_dot <= 35'(r_p1) + 35'(r_p2) + 35'sd4096;
                    r_cs  <= 64'(r_c1 * r_c1) + 64'(r_c2 * r_c2)
                           + 64'((r_p3 - r_p4) * (r_p3 - r_p4));
                    r_es  <= 36'(r_p5) + 36'(r_p6);
                    r_sqrt_go <= 1'b1;
                    r_state <= S_SQRTC;
                end
                S_SQRTC: if (w_sq_done) begin
                    if (!w_dotw[35]) begin
                        r_x <= CORDIC_W'(w_dotw) <<< 20;
                        r_y <= CORDIC_W'({1'b0, w_cr}) <<< 20;
                        r_z <= '0;
                    end else begin
                        r_x <= CORDIC_W'({1'b0, w_cr}) <<< 20;
                        r_y <= CORDIC_W'(-w_dotw) <<< 20;
                        r_z <= DEG90_Q16;
                    end
                    r_i <= '0;
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (r_y > 0) begin
                        r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + w_at;
                    end else begin
                        r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - w_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_state   <= S_SQRTE;
                        r_sqrt_go <= 1'b1;
                    end
                end
                S_SQRTE: if (w_sq_done) begin
                    if (r_z[ZW-1]) begin
                    end else if (r_z > DEG180_Q16) begin
                        r_angle_sum <= r_angle_sum + 64'(DEG180_Q16);
                    end else begin
                        r_angle_sum <= r_angle_sum + 64'(r_z);
                    end
                    r_ep_sum <= r_ep_sum + 64'((33'(w_sq_root) + 33'd1) >> 1);
                    if (r_es > 36'(w_th2)) r_bad <= r_bad + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_last) begin
                        r_state  <= S_DIVA;
                        r_div_go <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIVA: if (w_dv_done) begin
                    r_o_angle <= w_quot[15:0];
                    r_div_go  <= 1'b1;
                    r_state   <= S_DIVE;
                end
                S_DIVE: if (w_dv_done) begin
                    r_o_ep   <= w_quot[16:0];
                    r_div_go <= 1'b1;
                    r_state  <= S_DIVB;
                end
                S_DIVB: if (w_dv_done) begin
                    r_o_bad <= w_quot[16:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_o_sv   <= (r_cnt != '0);
                    r_o_cnt  <= 23'(r_cnt);
                    r_ovalid <= 1'b1;
                    r_angle_sum <= '0;
                    r_ep_sum <= '0;
                    r_bad    <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // empty frame forces zeros (divider by zero gives garbage)
    assign o_valid               = r_ovalid;
    assign o_stats_valid         = r_o_sv;
    assign o_counted_pixels      = r_o_sv ? r_o_cnt : '0;
    assign o_mean_angle_deg      = r_o_sv ? r_o_angle : '0;
    assign o_mean_endpoint_error = r_o_sv ? r_o_ep : '0;
    assign o_bad_fraction        = r_o_sv ? r_o_bad : '0;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("ready while busy");
    a_bad_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad <= r_cnt) else $error("bad count above pixel count");
    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_cnt == '0 && r_ovalid)) else $error("frame not closed");
endmodule

### tb/optical_flow_error_metrics_checker.sv
`timescale 1ns / 1ps
// watches the pixel, result and threshold channels of the optical flow error metrics core,
// predicts each frame result and compares it field by field; no dependencies
module optical_flow_error_metrics_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [15:0] i_truth_u,
    input  logic signed [15:0] i_truth_v,
    input  logic signed [15:0] i_est_u,
    input  logic signed [15:0] i_est_v,
    input  logic               i_pixel_enabled,
    input  logic               i_truth_unknown,
    input  logic               i_est_unknown,
    input  logic               i_last_pixel,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [15:0]        i_mean_angle_deg,
    input  logic [16:0]        i_mean_endpoint_error,
    input  logic [16:0]        i_bad_fraction,
    input  logic [22:0]        i_counted_pixels,
    input  logic               i_stats_valid,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [15:0] angle;
        logic [16:0] epe;
        logic [16:0] bad;
        logic [22:0] count;
        logic        ok;
    } t_frame_stats;

    localparam longint DEG90  = 5898240;
    localparam longint DEG180 = 11796480;
    localparam longint COUNT_FULL = longint'(1) << 22;
    localparam longint ATAN_DEG [18] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    t_frame_stats frame_q[$];
    longint unsigned thresh;
    longint unsigned angle_acc, epe_acc, bad_acc, pix_acc;

    assign o_pending = frame_q.size();

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // angle between (tu,tv,64) and (eu,ev,64) in degrees q16.16
    function automatic longint flow_angle(input longint tu, input longint tv,
                                          input longint eu, input longint ev);
        longint dot, c1, c2, c3, cr, x, y, z, xs, ys;
        longint unsigned cs;
        dot = tu * eu + tv * ev + 4096;
        c1 = 64 * (tv - ev);
        c2 = 64 * (eu - tu);
        c3 = tu * ev - tv * eu;
        cs = longint'(c1 * c1) + longint'(c2 * c2) + longint'(c3 * c3);
        cr = longint'(root_floor(cs));
        if (dot >= 0) begin
            x = dot; y = cr; z = 0;
        end else begin
            x = cr; y = -dot; z = DEG90;
        end
        x = x <<< 20;
        y = y <<< 20;
        for (int i = 0; i < 18; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_DEG[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_DEG[i];
            end
        end
        if (z < 0) z = 0;
        if (z > DEG180) z = DEG180;
        return z;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        longint tu, tv, eu, ev, du, dv;
        longint unsigned s;
        t_frame_stats r, e;
        if (!i_rst_n) begin
            thresh = 192;
            angle_acc = 0; epe_acc = 0; bad_acc = 0; pix_acc = 0;
            frame_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) thresh = 64'(i_cfg_data);
            if (i_valid && !i_stall_in) begin
                tu = longint'(i_truth_u); tv = longint'(i_truth_v);
                eu = longint'(i_est_u);   ev = longint'(i_est_v);
                if (i_pixel_enabled && !i_truth_unknown && !i_est_unknown
                        && pix_acc < COUNT_FULL) begin
                    du = tu - eu;
                    dv = tv - ev;
                    s = longint'(du * du) + longint'(dv * dv);
                    angle_acc += flow_angle(tu, tv, eu, ev);
                    epe_acc += (root_floor(4 * s) + 1) >> 1;
                    if (s > thresh * thresh) bad_acc++;
                    pix_acc++;
                end
                if (i_last_pixel) begin
                    e = '0;
                    if (pix_acc != 0) begin
                        e.angle = 16'((angle_acc + 128 * pix_acc) / (256 * pix_acc));
                        e.epe   = 17'((epe_acc + pix_acc / 2) / pix_acc);
                        e.bad   = 17'((bad_acc * 65536 + pix_acc / 2) / pix_acc);
                        e.count = 23'(pix_acc);
                        e.ok    = 1'b1;
                    end
                    frame_q.push_back(e);
                    angle_acc = 0; epe_acc = 0; bad_acc = 0; pix_acc = 0;
                end
            end
            if (i_res_valid && !i_res_stall) begin
                r = '{i_mean_angle_deg, i_mean_endpoint_error, i_bad_fraction,
                      i_counted_pixels, i_stats_valid};
                if (frame_q.size() == 0) begin
                    report("unexpected result beat", 0, 0);
                end else begin
                    e = frame_q.pop_front();
                    if (r.angle !== e.angle) report("mean_angle_deg", r.angle, e.angle);
                    if (r.epe !== e.epe) report("mean_endpoint_error", r.epe, e.epe);
                    if (r.bad !== e.bad) report("bad_fraction", r.bad, e.bad);
                    if (r.count !== e.count) report("counted_pixels", r.count, e.count);
                    if (r.ok !== e.ok) report("stats_valid", r.ok, e.ok);
                end
            end
        end
    end

endmodule

### tb/optical_flow_error_metrics_core_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the optical flow error metrics core
// depends on optical_flow_error_metrics_core and optical_flow_error_metrics_checker
module optical_flow_error_metrics_core_tb;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_WAIT = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [16:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_truth_u, i_truth_v, i_est_u, i_est_v;
    logic               i_pixel_enabled, i_truth_unknown, i_est_unknown, i_last_pixel;
    logic               o_valid;
    logic               i_stall;
    logic [15:0]        o_mean_angle_deg;
    logic [16:0]        o_mean_endpoint_error;
    logic [16:0]        o_bad_fraction;
    logic [22:0]        o_counted_pixels;
    logic               o_stats_valid;
    int                 fail_count;
    int                 frames_pending;
    logic               calm;
    int                 stall_left;
    int                 idle_cycles;

    optical_flow_error_metrics_core uut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_valid, .o_stall, .i_truth_u, .i_truth_v, .i_est_u, .i_est_v,
        .i_pixel_enabled, .i_truth_unknown, .i_est_unknown, .i_last_pixel,
        .o_valid, .i_stall, .o_mean_angle_deg, .o_mean_endpoint_error,
        .o_bad_fraction, .o_counted_pixels, .o_stats_valid
    );

    optical_flow_error_metrics_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_truth_u, .i_truth_v, .i_est_u, .i_est_v,
        .i_pixel_enabled, .i_truth_unknown, .i_est_unknown, .i_last_pixel,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_mean_angle_deg(o_mean_angle_deg),
        .i_mean_endpoint_error(o_mean_endpoint_error), .i_bad_fraction(o_bad_fraction),
        .i_counted_pixels(o_counted_pixels), .i_stats_valid(o_stats_valid),
        .o_fail_count(fail_count), .o_pending(frames_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 19);
        end else begin
            i_stall <= 1'b0;
            stall_left <= $urandom_range(0, 40);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input logic signed [15:0] tu, input logic signed [15:0] tv,
                              input logic signed [15:0] eu, input logic signed [15:0] ev,
                              input logic en, input logic tunk, input logic eunk,
                              input logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_truth_u <= tu; i_truth_v <= tv; i_est_u <= eu; i_est_v <= ev;
        i_pixel_enabled <= en; i_truth_unknown <= tunk; i_est_unknown <= eunk;
        i_last_pixel <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender holds off until every frame result is back, lets the core settle, then writes the new threshold
    task automatic drain_and_set(input logic [16:0] thr);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] near(input logic signed [15:0] v);
        return v + 16'($signed($urandom_range(0, 600)) - 300);
    endfunction

    task automatic send_random_pixel(input logic last);
        logic signed [15:0] tu, tv, eu, ev;
        int mode;
        mode = $urandom_range(0, 9);
        tu = 16'($urandom); tv = 16'($urandom);
        if (mode < 3) begin
            eu = 16'($urandom); ev = 16'($urandom);
        end else begin
            if (mode < 6) begin
                tu = 16'($signed($urandom_range(0, 1023)) - 512);
                tv = 16'($signed($urandom_range(0, 1023)) - 512);
            end
            eu = near(tu); ev = near(tv);
        end
        send_pixel(tu, tv, eu, ev, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0, last);
    endtask

    initial begin
        logic [16:0] thr_list [5];
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        i_valid = 1'b0;
        i_truth_u = '0; i_truth_v = '0; i_est_u = '0; i_est_v = '0;
        i_pixel_enabled = 1'b0; i_truth_unknown = 1'b0; i_est_unknown = 1'b0;
        i_last_pixel = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single zero-flow pixel frame right after reset, default threshold
        send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1);
        // extremes, opposite and equal flow, skipped pixels
        send_pixel(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd64, 16'sd0, -16'sd64, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_pixel(16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_pixel(16'sd192, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd193, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1);
        // last pixel that is itself skipped
        send_pixel(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd5, 16'sd5, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1);
        drain_and_set(17'd0);
        send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b1);
        drain_and_set(17'd92682);
        send_pixel(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pixel(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b1);
        send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1);

        thr_list = '{17'd0, 17'd92682, 17'($urandom_range(0, 92682)), 17'd64, 17'd192};
        foreach (thr_list[p]) begin
            drain_and_set(thr_list[p]);
            calm = (p == 4);
            for (int k = 0; k < 160; k++)
                send_random_pixel(k == 159 || $urandom_range(0, 7) == 0);
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
src/ofem_pkg.sv
src/ofem_isqrt.sv
src/ofem_divider.sv
src/optical_flow_error_metrics_core.sv
tb/optical_flow_error_metrics_checker.sv
tb/optical_flow_error_metrics_core_tb.sv
